FILE: rtl/core/khs_pkg.sv
package khs_pkg;

   // default heap depth, the largest rank that can be selected
   localparam int MAX_K_DEF = 64;

   localparam int DATA_W = 32;
   localparam int SEL_W  = 7;
   localparam int CSR_IDX_W = 2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAN_ENABLE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SELECT_COUNT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_THRESH     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_PIXEL_THRESH = 2'd3;

   // reset values of the configuration registers
   localparam logic             CLEAN_ENABLE_RST = 1'b1;
   localparam logic [SEL_W-1:0] SELECT_COUNT_RST = 7'd5;

   // top level sequencer
   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_DECIDE,
      TOP_WAIT,
      TOP_FINISH
   } top_state_type;

   // sift engine sequencer
   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_UP_RD,
      ENG_UP_CMP,
      ENG_DN_RDL,
      ENG_DN_RDR,
      ENG_DN_SEL,
      ENG_DN_CMP,
      ENG_WR_FIN
   } eng_state_type;

   // command from the top sequencer to the sift engine
   typedef struct packed {
      logic                     start;
      logic                     sift_down;
      logic signed [DATA_W-1:0] value;
   } sift_cmd_type;

   // status from the sift engine
   typedef struct packed {
      logic                     busy;
      logic                     done;
      logic signed [DATA_W-1:0] root_value;
   } sift_stat_type;

endpackage

FILE: rtl/core/khs_ram.sv
module khs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/khs_sift.sv
module khs_sift import khs_pkg::*; #(
   parameter int MAX_K = MAX_K_DEF,
   localparam int AW = $clog2(MAX_K),
   localparam int CW = $clog2(MAX_K + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  sift_cmd_type  cmd,
   input  logic [AW-1:0] index,
   input  logic [CW-1:0] k_count,
   output sift_stat_type stat
);

   localparam int XW = AW + 2;

   eng_state_type state_ff, state_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic signed [DATA_W-1:0] m_ff, m_in;
   logic signed [DATA_W-1:0] root_ff, root_in;
   logic [AW-1:0] j_ff, j_in;
   logic [AW-1:0] c_ff, c_in;

   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic signed [DATA_W-1:0] wr_data;
   logic [AW-1:0]            rd_addr;
   logic [DATA_W-1:0]        rd_raw;
   logic signed [DATA_W-1:0] rd_data;

   logic [XW-1:0] k_ext;
   logic          k_le_one;
   logic          right_ok;
   logic          next_leaf;
   logic          up_stop;
   logic          right_less;
   logic          dn_stop;
   logic [AW-1:0] parent;

   khs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_K)
   ) u_heap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_data = $signed(rd_raw);

   // shared index and compare logic
   assign k_ext      = XW'(k_count);
   assign k_le_one   = (k_ext <= XW'(1));
   assign right_ok   = ((XW'(c_ff) + XW'(1)) < k_ext);
   assign next_leaf  = (XW'({c_ff, 1'b1}) >= k_ext);
   assign parent     = (j_ff - AW'(1)) >> 1;
   assign up_stop    = (rd_data <= val_ff);
   assign right_less = (rd_data < m_ff);
   assign dn_stop    = (val_ff <= m_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ENG_IDLE: begin
            if (cmd.start) begin
               if (cmd.sift_down) begin
                  state_in = k_le_one ? ENG_WR_FIN : ENG_DN_RDL;
               end else begin
                  state_in = (index == '0) ? ENG_WR_FIN : ENG_UP_RD;
               end
            end
         end
         ENG_UP_RD:  state_in = ENG_UP_CMP;
         ENG_UP_CMP: begin
            if (up_stop || c_ff == '0) begin
               state_in = ENG_WR_FIN;
            end else begin
               state_in = ENG_UP_RD;
            end
         end
         ENG_DN_RDL: state_in = ENG_DN_RDR;
         ENG_DN_RDR: state_in = right_ok ? ENG_DN_SEL : ENG_DN_CMP;
         ENG_DN_SEL: state_in = ENG_DN_CMP;
         ENG_DN_CMP: begin
            if (dn_stop || next_leaf) begin
               state_in = ENG_WR_FIN;
            end else begin
               state_in = ENG_DN_RDL;
            end
         end
         ENG_WR_FIN: state_in = ENG_IDLE;
         default:    state_in = ENG_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      val_in  = val_ff;
      m_in    = m_ff;
      j_in    = j_ff;
      c_in    = c_ff;
      wr_en   = 1'b0;
      wr_addr = j_ff;
      wr_data = val_ff;
      rd_addr = c_ff;
      case (state_ff)
         ENG_IDLE: begin
            if (cmd.start) begin
               val_in = cmd.value;
               if (cmd.sift_down) begin
                  j_in = '0;
                  c_in = AW'(1);
               end else begin
                  j_in = index;
               end
            end
         end
         // hole moves up: fetch the parent
         ENG_UP_RD: begin
            rd_addr = parent;
            c_in    = parent;
         end
         ENG_UP_CMP: begin
            if (!up_stop) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               j_in    = c_ff;
            end
         end
         // hole moves down: fetch both children, keep the smaller
         ENG_DN_RDL: begin
            rd_addr = c_ff;
         end
         ENG_DN_RDR: begin
            m_in    = rd_data;
            rd_addr = c_ff + AW'(1);
         end
         ENG_DN_SEL: begin
            if (right_less) begin
               m_in = rd_data;
               c_in = c_ff + AW'(1);
            end
         end
         ENG_DN_CMP: begin
            if (!dn_stop) begin
               wr_en   = 1'b1;
               wr_data = m_ff;
               j_in    = c_ff;
               c_in    = AW'({c_ff, 1'b1});
            end
         end
         ENG_WR_FIN: begin
            wr_en = 1'b1;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // cached root for the replace decision
   assign root_in = (wr_en && wr_addr == '0) ? wr_data : root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
      end else begin
         state_ff <= state_in;
      end
      val_ff  <= val_in;
      m_ff    <= m_in;
      j_ff    <= j_in;
      c_ff    <= c_in;
      root_ff <= root_in;
   end

   assign stat.busy       = (state_ff != ENG_IDLE);
   assign stat.done       = (state_ff == ENG_WR_FIN);
   assign stat.root_value = root_ff;

endmodule

FILE: rtl/core/kth_largest_heap_select_core.sv
// channel   dir   handshake              payload
// req       in    req_tvalid/req_tready  tdata: conv_value, pixel_thresh; tlast: last_pixel
// rsp       out   rsp_tvalid/rsp_tready  tdata: kth_value; tuser: enough_pixels
// csr       in    csr_valid/csr_ready    csr_index, csr_data
//
// an item is accepted and decided, then sifted into the heap if it enters it:
// sift-up on a fill and sift-down on a root replace, one heap read port
// being the limit; no new item is taken before the last one is finished;
// reset is synchronous and clears control state only; the heap needs no
// clearing pass, as entries are read only after they have been written
// a stalled rsp holds the last item of an object until the output register
// frees up; csr writes are always taken
module kth_largest_heap_select_core import khs_pkg::*; #(
   parameter int MAX_K = MAX_K_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // conv_value [31:0], pixel_thresh [63:32]
   input  logic [63:0]          req_tdata,
   input  logic                 req_tlast,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // kth_value [31:0]
   output logic [31:0]          rsp_tdata,
   // enough_pixels [0]
   output logic                 rsp_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   localparam int AW  = $clog2(MAX_K);
   localparam int CW  = $clog2(MAX_K + 1);
   localparam int KXW = (CW > SEL_W) ? CW : SEL_W;

   // configuration registers
   logic                     clean_en_ff;
   logic [SEL_W-1:0]         sel_cnt_ff;
   logic signed [DATA_W-1:0] fixed_thr_ff;
   logic                     use_pix_ff;

   top_state_type state_ff, state_in;
   logic signed [DATA_W-1:0] score_ff, score_in;
   logic                     last_ff, last_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            k_ff, k_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]        rsp_data_ff, rsp_data_in;
   logic                     rsp_user_ff, rsp_user_in;

   logic signed [DATA_W-1:0] conv;
   logic signed [DATA_W-1:0] thr;
   logic signed [DATA_W:0]   diff;
   logic signed [DATA_W-1:0] score_sat;
   logic [KXW-1:0]           k_raw;
   logic [CW-1:0]            k_eff;
   logic [CW-1:0]            k_use;
   logic                     filling;
   logic                     out_free;
   logic                     enough;
   logic                     accept;
   logic                     load_out;

   sift_cmd_type  cmd;
   sift_stat_type stat;

   khs_sift #(
      .MAX_K (MAX_K)
   ) u_sift (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .index   (count_ff[AW-1:0]),
      .k_count (k_use),
      .stat    (stat)
   );

   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clean_en_ff  <= CLEAN_ENABLE_RST;
         sel_cnt_ff   <= SELECT_COUNT_RST;
         fixed_thr_ff <= '0;
         use_pix_ff   <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CLEAN_ENABLE:     clean_en_ff  <= csr_data[0];
            CSR_SELECT_COUNT:     sel_cnt_ff   <= csr_data[SEL_W-1:0];
            CSR_FIXED_THRESH:     fixed_thr_ff <= $signed(csr_data);
            CSR_USE_PIXEL_THRESH: use_pix_ff   <= csr_data[0];
            default:              use_pix_ff   <= use_pix_ff;
         endcase
      end
   end

   // score: saturating difference of value and threshold
   assign conv = $signed(req_tdata[31:0]);
   assign thr  = use_pix_ff ? $signed(req_tdata[63:32]) : fixed_thr_ff;
   assign diff = {conv[DATA_W-1], conv} - {thr[DATA_W-1], thr};

   always_comb begin
      if (diff[DATA_W] != diff[DATA_W-1]) begin
         score_sat = diff[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                  : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         score_sat = diff[DATA_W-1:0];
      end
   end

   // rank clamped to 1..MAX_K, latched on the first pixel of an object
   always_comb begin
      k_raw = KXW'(sel_cnt_ff);
      if (k_raw == '0) begin
         k_raw = KXW'(1);
      end
      if (k_raw > KXW'(MAX_K)) begin
         k_raw = KXW'(MAX_K);
      end
      k_eff = k_raw[CW-1:0];
   end

   assign k_use    = (count_ff == '0) ? k_eff : k_ff;
   assign filling  = (count_ff < k_use);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign enough   = clean_en_ff && (count_ff >= k_ff);
   assign accept   = req_tvalid && req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         TOP_IDLE: begin
            if (accept) begin
               state_in = TOP_DECIDE;
            end
         end
         TOP_DECIDE: begin
            if (filling || score_ff > stat.root_value) begin
               state_in = TOP_WAIT;
            end else begin
               state_in = TOP_FINISH;
            end
         end
         TOP_WAIT: begin
            if (stat.done) begin
               state_in = TOP_FINISH;
            end
         end
         TOP_FINISH: begin
            if (!last_ff || out_free) begin
               state_in = TOP_IDLE;
            end
         end
         default: state_in = TOP_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_tready    = 1'b0;
      cmd.start     = 1'b0;
      cmd.sift_down = !filling;
      cmd.value     = score_ff;
      score_in      = score_ff;
      last_in       = last_ff;
      count_in      = count_ff;
      k_in          = k_ff;
      load_out      = 1'b0;
      case (state_ff)
         TOP_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               score_in = score_sat;
               last_in  = req_tlast;
            end
         end
         TOP_DECIDE: begin
            k_in      = k_use;
            cmd.start = filling || score_ff > stat.root_value;
            if (count_ff < CW'(MAX_K)) begin
               count_in = count_ff + CW'(1);
            end
         end
         TOP_FINISH: begin
            if (last_ff && out_free) begin
               load_out = 1'b1;
               count_in = '0;
            end
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = enough ? stat.root_value : '0;
         rsp_user_in  = enough;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_IDLE;
         count_ff     <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      score_ff    <= score_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   // no item is taken while the sift engine still works on the last one
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !stat.busy)
      else $error("item accepted while sift engine busy");

   // pixel count saturates at the heap depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_K))
      else $error("pixel count beyond heap depth");

   // a result without enough pixels carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("nonzero value without enough pixels");

   // the engine starts only from the decide step
   assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> state_ff == TOP_DECIDE && !stat.busy)
      else $error("sift started outside decide step");
`endif

endmodule
